>>> sv/fea_pkg.sv
// ---------------------------------------------------------------------------
// fea_pkg
// Shared types, codes and defaults for the free extent allocator.
// ---------------------------------------------------------------------------
package fea_pkg;

   localparam int FIELD_W         = 16;
   localparam int OP_W            = 2;
   localparam int STATUS_W        = 2;
   localparam int COUNT_OUT_W     = 5;
   localparam int DEF_MAX_EXTENTS = 16;
   localparam int DEF_ADDR_BITS   = 16;

   localparam logic [FIELD_W-1:0] DISK_SIZE_RST = 16'hFFFF;

   localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_RD,
      S_ALLOC_CHK,
      S_STREAM_RD,
      S_STREAM_FEED,
      S_STREAM_TAIL,
      S_FLUSH
   } fea_state_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [FIELD_W-1:0] request_start;
      logic [FIELD_W-1:0] request_length;
   } fea_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [FIELD_W-1:0]     alloc_start;
      logic [COUNT_OUT_W-1:0] free_extents;
   } fea_rsp_type;

endpackage

>>> sv/fea_extent_ram.sv
// ---------------------------------------------------------------------------
// fea_extent_ram
// Extent table storage: one write port, one registered read port.
// ---------------------------------------------------------------------------
module fea_extent_ram #(
   parameter int DEPTH  = fea_pkg::DEF_MAX_EXTENTS,
   parameter int ADDR_W = fea_pkg::DEF_ADDR_BITS,
   parameter int IDX_W  = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [ADDR_W-1:0] wr_start,
   input  logic [ADDR_W-1:0] wr_len,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [ADDR_W-1:0] rd_start,
   output logic [ADDR_W-1:0] rd_len
);
   logic [2*ADDR_W-1:0] mem [DEPTH];
   logic [2*ADDR_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {wr_start, wr_len};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_idx];
      end
   end

   assign rd_start = rd_ff[2*ADDR_W-1:ADDR_W];
   assign rd_len   = rd_ff[ADDR_W-1:0];

endmodule

>>> sv/fea_coalesce_unit.sv
// ---------------------------------------------------------------------------
// fea_coalesce_unit
// Adjacency test and saturating length sum for two extents.
// ---------------------------------------------------------------------------
module fea_coalesce_unit #(
   parameter int ADDR_W = fea_pkg::DEF_ADDR_BITS
) (
   input  logic [ADDR_W-1:0] a_start,
   input  logic [ADDR_W-1:0] a_len,
   input  logic [ADDR_W-1:0] b_start,
   input  logic [ADDR_W-1:0] b_len,
   output logic              adjacent,
   output logic [ADDR_W-1:0] sum_len
);
   logic [ADDR_W:0] a_end;
   logic [ADDR_W:0] len_sum;

   assign a_end    = {1'b0, a_start} + {1'b0, a_len};
   assign adjacent = (a_end == {1'b0, b_start});
   assign len_sum  = {1'b0, a_len} + {1'b0, b_len};
   assign sum_len  = len_sum[ADDR_W] ? {ADDR_W{1'b1}} : len_sum[ADDR_W-1:0];

endmodule

>>> sv/free_extent_allocator.sv
// ---------------------------------------------------------------------------
// free_extent_allocator
// Free extent table, sorted by start, with allocate, free and coalescing.
// ---------------------------------------------------------------------------
// Requests enter on req_data when start is high and busy is low. Each request
// gives one response on rsp_data, marked by a one-cycle rsp_strobe; the
// receiver cannot stall it. csr_wr_data is written to disk_size whenever
// csr_wr_en is high; write it only while the block is idle.
// Init, no-op and requests rejected on acceptance are answered from the idle
// state; an allocate reads and checks the first extent, and an allocate that
// empties it, or a free, then streams the table once through the single table
// read port, reading and then feeding each extent, merging neighbors in one
// shared adjacency/sum unit. busy stays high until the request is finished;
// the next request may be accepted while the response strobe is showing.
// Reset empties the table, sets disk_size to 65535 and needs no clearing pass.
// ---------------------------------------------------------------------------
module free_extent_allocator #(
   parameter int MAX_EXTENTS = fea_pkg::DEF_MAX_EXTENTS,
   parameter int ADDR_BITS   = fea_pkg::DEF_ADDR_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  fea_pkg::fea_req_type         req_data,
   output logic                         rsp_strobe,
   output fea_pkg::fea_rsp_type         rsp_data,
   input  logic                         csr_wr_en,
   input  logic [fea_pkg::FIELD_W-1:0]  csr_wr_data
);
   import fea_pkg::*;

   localparam int IDX_W = $clog2(MAX_EXTENTS);
   localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

   fea_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ADDR_BITS-1:0] cur_start_ff, cur_start_in;
   logic [ADDR_BITS-1:0] cur_len_ff, cur_len_in;
   logic                 cur_vld_ff, cur_vld_in;
   logic                 ins_ff, ins_in;
   logic                 merge_ff, merge_in;
   logic [ADDR_BITS-1:0] rstart_ff, rstart_in;
   logic [ADDR_BITS-1:0] rlen_ff, rlen_in;
   logic [ADDR_BITS-1:0] astart_ff, astart_in;
   logic [FIELD_W-1:0]   disk_ff;
   logic                 rsp_strobe_ff;
   fea_rsp_type          rsp_ff, rsp_in;

   logic                 accept;
   logic [ADDR_BITS-1:0] req_start;
   logic [ADDR_BITS-1:0] req_len;
   logic [ADDR_BITS-1:0] disk_len;
   logic                 table_full;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   logic [ADDR_BITS-1:0] wr_start;
   logic [ADDR_BITS-1:0] wr_len;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_idx;
   logic [ADDR_BITS-1:0] rd_start;
   logic [ADDR_BITS-1:0] rd_len;

   logic                 feed_en;
   logic [ADDR_BITS-1:0] feed_start;
   logic [ADDR_BITS-1:0] feed_len;
   logic                 adjacent;
   logic [ADDR_BITS-1:0] sum_len;
   logic                 ins_sel;

   logic                 done;
   logic [STATUS_W-1:0]  done_status;
   logic [ADDR_BITS-1:0] done_astart;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign req_start  = ADDR_BITS'(req_data.request_start);
   assign req_len    = ADDR_BITS'(req_data.request_length);
   assign disk_len   = ADDR_BITS'(disk_ff);
   assign table_full = (cnt_ff == CNT_W'(MAX_EXTENTS));
   assign ins_sel    = !ins_ff && (rd_start >= rstart_ff);
   assign rd_idx     = rd_ptr_ff[IDX_W-1:0];

   fea_extent_ram #(
      .DEPTH  (MAX_EXTENTS),
      .ADDR_W (ADDR_BITS),
      .IDX_W  (IDX_W)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_start (wr_start),
      .wr_len   (wr_len),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx),
      .rd_start (rd_start),
      .rd_len   (rd_len)
   );

   fea_coalesce_unit #(
      .ADDR_W (ADDR_BITS)
   ) u_coalesce (
      .a_start  (cur_start_ff),
      .a_len    (cur_len_ff),
      .b_start  (feed_start),
      .b_len    (feed_len),
      .adjacent (adjacent),
      .sum_len  (sum_len)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.operation == OP_ALLOC && cnt_ff != '0) begin
                  state_in = S_ALLOC_RD;
               end else if (req_data.operation == OP_FREE && req_len != '0 &&
                            !table_full) begin
                  state_in = S_STREAM_RD;
               end
            end
         end
         S_ALLOC_RD: begin
            state_in = S_ALLOC_CHK;
         end
         S_ALLOC_CHK: begin
            if (rd_len < rlen_ff || rd_len != rlen_ff) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_STREAM_RD;
            end
         end
         S_STREAM_RD: begin
            state_in = (rd_ptr_ff == cnt_ff) ? S_STREAM_TAIL : S_STREAM_FEED;
         end
         S_STREAM_FEED: begin
            state_in = ins_sel ? S_STREAM_FEED : S_STREAM_RD;
         end
         S_STREAM_TAIL: begin
            state_in = ins_ff ? S_FLUSH : S_STREAM_TAIL;
         end
         S_FLUSH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      cur_start_in = cur_start_ff;
      cur_len_in   = cur_len_ff;
      cur_vld_in   = cur_vld_ff;
      ins_in       = ins_ff;
      merge_in     = merge_ff;
      rstart_in    = rstart_ff;
      rlen_in      = rlen_ff;
      astart_in    = astart_ff;
      wr_en        = 1'b0;
      wr_idx       = wr_ptr_ff[IDX_W-1:0];
      wr_start     = cur_start_ff;
      wr_len       = cur_len_ff;
      rd_en        = 1'b0;
      feed_en      = 1'b0;
      feed_start   = rd_start;
      feed_len     = rd_len;
      done         = 1'b0;
      done_status  = ST_OK;
      done_astart  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rstart_in = req_start;
               rlen_in   = req_len;
               astart_in = '0;
               if (req_data.operation == OP_INIT) begin
                  wr_en    = 1'b1;
                  wr_idx   = '0;
                  wr_start = '0;
                  wr_len   = disk_len;
                  cnt_in   = (disk_len != '0) ? CNT_W'(1) : '0;
                  done     = 1'b1;
               end else if (req_data.operation == OP_ALLOC) begin
                  rd_ptr_in = '0;
                  if (cnt_ff == '0) begin
                     done        = 1'b1;
                     done_status = ST_NOSPACE;
                  end
               end else if (req_data.operation == OP_FREE) begin
                  if (req_len == '0) begin
                     done = 1'b1;
                  end else if (table_full) begin
                     done        = 1'b1;
                     done_status = ST_FULL;
                  end else begin
                     rd_ptr_in  = '0;
                     wr_ptr_in  = '0;
                     cur_vld_in = 1'b0;
                     ins_in     = 1'b0;
                     merge_in   = 1'b1;
                  end
               end else begin
                  done = 1'b1;
               end
            end
         end
         S_ALLOC_RD: begin
            rd_en = 1'b1;
         end
         S_ALLOC_CHK: begin
            if (rd_len < rlen_ff) begin
               done        = 1'b1;
               done_status = ST_NOSPACE;
            end else if (rd_len != rlen_ff) begin
               wr_en       = 1'b1;
               wr_idx      = '0;
               wr_start    = rd_start + rlen_ff;
               wr_len      = rd_len - rlen_ff;
               done        = 1'b1;
               done_astart = rd_start;
            end else begin
               astart_in  = rd_start;
               rd_ptr_in  = CNT_W'(1);
               wr_ptr_in  = '0;
               cur_vld_in = 1'b0;
               ins_in     = 1'b1;
               merge_in   = 1'b0;
            end
         end
         S_STREAM_RD: begin
            rd_en = (rd_ptr_ff != cnt_ff);
         end
         S_STREAM_FEED: begin
            feed_en = 1'b1;
            if (ins_sel) begin
               feed_start = rstart_ff;
               feed_len   = rlen_ff;
               ins_in     = 1'b1;
            end else begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
         end
         S_STREAM_TAIL: begin
            if (!ins_ff) begin
               feed_en    = 1'b1;
               feed_start = rstart_ff;
               feed_len   = rlen_ff;
               ins_in     = 1'b1;
            end
         end
         S_FLUSH: begin
            wr_en       = cur_vld_ff;
            cnt_in      = wr_ptr_ff + CNT_W'(cur_vld_ff);
            done        = 1'b1;
            done_astart = astart_ff;
         end
         default: begin
            done = 1'b0;
         end
      endcase

      if (feed_en) begin
         if (cur_vld_ff && merge_ff && adjacent) begin
            cur_len_in = sum_len;
         end else begin
            wr_en        = cur_vld_ff;
            wr_ptr_in    = wr_ptr_ff + CNT_W'(cur_vld_ff);
            cur_start_in = feed_start;
            cur_len_in   = feed_len;
            cur_vld_in   = 1'b1;
         end
      end

      rsp_in.status       = done_status;
      rsp_in.alloc_start  = FIELD_W'(done_astart);
      rsp_in.free_extents = COUNT_OUT_W'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         disk_ff       <= DISK_SIZE_RST;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= done;
         if (csr_wr_en) begin
            disk_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      cur_start_ff <= cur_start_in;
      cur_len_ff   <= cur_len_in;
      cur_vld_ff   <= cur_vld_in;
      ins_ff       <= ins_in;
      merge_ff     <= merge_in;
      rstart_ff    <= rstart_in;
      rlen_ff      <= rlen_in;
      astart_ff    <= astart_in;
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the free extent allocator: a class mirrors the
// sorted extent table and predicts each response. Directed corner requests
// are followed by random init/allocate/free/no-op traffic under several disk sizes.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fea_pkg::*;

   localparam logic [OP_W-1:0] OP_NOP = 2'd3;
   localparam int MAX_EXT     = DEF_MAX_EXTENTS;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 110;
   localparam int NUM_PHASES  = 7;

   typedef struct packed {
      logic [FIELD_W-1:0] base;
      logic [FIELD_W-1:0] len;
   } loan_type;

   class extent_book;
      logic [FIELD_W-1:0] ext_start [MAX_EXT];
      logic [FIELD_W-1:0] ext_len [MAX_EXT];
      int                 ext_cnt;
      logic [FIELD_W-1:0] pool_size;
      fea_rsp_type        awaited_rsp [$];
      fea_rsp_type        last_rsp;
      int                 fail_cnt;

      function new();
         ext_cnt = 0;
         pool_size = DISK_SIZE_RST;
         fail_cnt = 0;
      endfunction

      function void set_pool_size(logic [FIELD_W-1:0] v);
         pool_size = v;
      endfunction

      function void drop_entry(int pos);
         for (int k = pos; k + 1 < ext_cnt; k++) begin
            ext_start[k] = ext_start[k+1];
            ext_len[k] = ext_len[k+1];
         end
         ext_cnt--;
      endfunction

      function void note_request(fea_req_type r);
         fea_rsp_type      rsp;
         int               pos;
         int               i;
         logic [FIELD_W:0] ext_end;
         logic [FIELD_W:0] sum;
         rsp = '0;
         rsp.status = ST_OK;
         case (r.operation)
            OP_INIT: begin
               if (pool_size == '0) begin
                  ext_cnt = 0;
               end else begin
                  ext_start[0] = '0;
                  ext_len[0] = pool_size;
                  ext_cnt = 1;
               end
            end
            OP_ALLOC: begin
               if (ext_cnt == 0 || ext_len[0] < r.request_length) begin
                  rsp.status = ST_NOSPACE;
               end else begin
                  rsp.alloc_start = ext_start[0];
                  ext_start[0] = ext_start[0] + r.request_length;
                  ext_len[0] = ext_len[0] - r.request_length;
                  if (ext_len[0] == '0) drop_entry(0);
               end
            end
            OP_FREE: begin
               if (r.request_length != '0) begin
                  if (ext_cnt >= MAX_EXT) begin
                     rsp.status = ST_FULL;
                  end else begin
                     pos = 0;
                     while (pos < ext_cnt && ext_start[pos] < r.request_start) pos++;
                     for (int k = ext_cnt; k > pos; k--) begin
                        ext_start[k] = ext_start[k-1];
                        ext_len[k] = ext_len[k-1];
                     end
                     ext_start[pos] = r.request_start;
                     ext_len[pos] = r.request_length;
                     ext_cnt++;
                     // merge neighbors whose unwrapped end meets the next start
                     i = 0;
                     while (i + 1 < ext_cnt) begin
                        ext_end = {1'b0, ext_start[i]} + {1'b0, ext_len[i]};
                        if (ext_end == {1'b0, ext_start[i+1]}) begin
                           sum = {1'b0, ext_len[i]} + {1'b0, ext_len[i+1]};
                           ext_len[i] = sum[FIELD_W] ? {FIELD_W{1'b1}} : sum[FIELD_W-1:0];
                           drop_entry(i + 1);
                        end else begin
                           i++;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         rsp.free_extents = COUNT_OUT_W'(ext_cnt);
         last_rsp = rsp;
         awaited_rsp.push_back(rsp);
      endfunction

      function void check_response(fea_rsp_type got);
         fea_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            fail_cnt++;
            return;
         end
         want = awaited_rsp.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_cnt++;
         end
         if (got.alloc_start !== want.alloc_start) begin
            $display("%0t: alloc_start expected %h actual %h", $time,
                     want.alloc_start, got.alloc_start);
            fail_cnt++;
         end
         if (got.free_extents !== want.free_extents) begin
            $display("%0t: free_extents expected %0d actual %0d", $time,
                     want.free_extents, got.free_extents);
            fail_cnt++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   fea_req_type        req_data = '0;
   logic               rsp_strobe;
   fea_rsp_type        rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [FIELD_W-1:0] csr_wr_data = '0;

   extent_book book = new();
   loan_type   loans [$];
   bit         gaps_on = 1'b0;
   int         stall_cycles = 0;

   free_extent_allocator #(
      .MAX_EXTENTS (DEF_MAX_EXTENTS),
      .ADDR_BITS   (DEF_ADDR_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) book.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic issue_request(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] s,
                                input logic [FIELD_W-1:0] l);
      fea_req_type r;
      loan_type    ln;
      r.operation = op;
      r.request_start = s;
      r.request_length = l;
      while (gaps_on && $urandom_range(99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do begin
         @(posedge clock);
      end while (busy);
      book.note_request(r);
      if (op == OP_INIT) begin
         loans.delete();
      end else if (op == OP_ALLOC && book.last_rsp.status == ST_OK && l != '0) begin
         ln.base = book.last_rsp.alloc_start;
         ln.len = l;
         loans.push_back(ln);
      end
   endtask

   // hold off until every response is in and the block is idle
   task automatic settle_pool();
      start <= 1'b0;
      @(posedge clock);
      while (book.awaited_rsp.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_pool_size(input logic [FIELD_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      book.set_pool_size(v);
   endtask

   task automatic random_phase(input int n);
      int                 pick;
      int                 sel;
      int                 idx;
      logic [OP_W-1:0]    op;
      logic [FIELD_W-1:0] s;
      logic [FIELD_W-1:0] l;
      for (int j = 0; j < n; j++) begin
         pick = $urandom_range(99);
         s = FIELD_W'($urandom);
         l = FIELD_W'($urandom);
         if (pick < 4) begin
            op = OP_INIT;
         end else if (pick < 46) begin
            op = OP_ALLOC;
            sel = $urandom_range(9);
            if (sel == 0) begin
               l = '0;
            end else if (sel == 1 && book.ext_cnt > 0) begin
               l = book.ext_len[0];
            end else if (sel > 2) begin
               l = FIELD_W'($urandom_range(1, book.pool_size / 16 + 1));
            end
         end else if (pick < 86 && loans.size() > 0) begin
            // return a previously granted extent
            op = OP_FREE;
            idx = $urandom_range(loans.size() - 1);
            s = loans[idx].base;
            l = loans[idx].len;
            loans.delete(idx);
         end else if (pick < 96) begin
            op = OP_FREE;
            l = FIELD_W'($urandom_range(0, 64));
         end else if (pick < 98) begin
            op = OP_NOP;
         end else begin
            op = OP_FREE;
         end
         issue_request(op, s, l);
      end
   endtask

   initial begin
      logic [FIELD_W-1:0] pool_sizes [NUM_PHASES];
      pool_sizes[0] = 16'h0000;
      pool_sizes[1] = 16'h0001;
      pool_sizes[2] = 16'd300;
      pool_sizes[3] = 16'hFFFF;
      pool_sizes[4] = 16'h8000;
      pool_sizes[5] = FIELD_W'($urandom_range(2, 65534));
      pool_sizes[6] = 16'hFFFF;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      issue_request(OP_ALLOC, 16'h0000, 16'd5);
      issue_request(OP_FREE, 16'h1234, 16'h0000);
      issue_request(OP_NOP, 16'hFFFF, 16'hFFFF);
      issue_request(OP_INIT, 16'h0000, 16'h0000);
      issue_request(OP_ALLOC, 16'h0000, 16'h0000);
      issue_request(OP_ALLOC, 16'hFFFF, 16'd100);
      issue_request(OP_ALLOC, 16'h0000, 16'hFFFF);
      issue_request(OP_FREE, 16'h0000, 16'd100);
      // merged length saturates
      issue_request(OP_FREE, 16'hFFFF, 16'hFFFF);
      // fill the table, inserting ahead of existing entries
      for (int k = 15; k > 0; k--) begin
         issue_request(OP_FREE, 16'(k * 16'h1000 + 16'h0800), 16'd1);
      end
      issue_request(OP_FREE, 16'h0010, 16'd4);
      issue_request(OP_ALLOC, 16'h0000, 16'hFFFF);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle_pool();
         write_pool_size(pool_sizes[p]);
         gaps_on = (p != 3);
         issue_request(OP_INIT, FIELD_W'($urandom), FIELD_W'($urandom));
         random_phase(PHASE_ITEMS);
      end

      settle_pool();
      repeat (50) @(posedge clock);
      if (book.awaited_rsp.size() != 0) begin
         $display("%0t: %0d responses expected but never seen", $time,
                  book.awaited_rsp.size());
      end
      if (book.fail_cnt == 0 && book.awaited_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
